>>> sv/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Types, codes and fixed keyword text shared by the command framer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

  // depth of the queued-send store, fixed by the host interface
  localparam int SEND_DEPTH = 20;
  localparam int SEND_AW    = 5;

  // index width into the longest answer text
  localparam int TXT_IW = 4;

  // frame delimiters
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // keyword and answer text, right-aligned, first character in the most significant used byte
  localparam logic [71:0] STR_RUOK    = "/RUOK!";
  localparam logic [71:0] STR_RUNA    = "/RUNA!";
  localparam logic [71:0] STR_RUNB    = "/RUNB!";
  localparam logic [71:0] STR_ZZZ     = "/ZZZ!";
  localparam logic [71:0] STR_IMHERE  = "/IMHERE!";
  localparam logic [71:0] STR_OK      = "/OK!";
  localparam logic [71:0] STR_NOK     = "/NOK!";
  localparam logic [71:0] STR_RUNNEDA = "/RUNNEDA!";
  localparam logic [71:0] STR_RUNNEDB = "/RUNNEDB!";

  localparam logic [3:0] LEN_RUOK    = 4'd6;
  localparam logic [3:0] LEN_RUNA    = 4'd6;
  localparam logic [3:0] LEN_RUNB    = 4'd6;
  localparam logic [3:0] LEN_ZZZ     = 4'd5;
  localparam logic [3:0] LEN_IMHERE  = 4'd8;
  localparam logic [3:0] LEN_OK      = 4'd4;
  localparam logic [3:0] LEN_NOK     = 4'd5;
  localparam logic [3:0] LEN_RUNNEDA = 4'd9;
  localparam logic [3:0] LEN_RUNNEDB = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STATUS,
    ST_TEXT,
    ST_MEM_RD,
    ST_MEM_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RECV,
    PH_HELD,
    PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    OP_LINE,
    OP_TAKE,
    OP_LOAD,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_HOST,
    KIND_STATUS
  } kind_t;

  typedef enum logic [2:0] {
    TXT_NONE,
    TXT_IMHERE,
    TXT_OK,
    TXT_NOK,
    TXT_RUNNEDA,
    TXT_RUNNEDB
  } txt_t;

  typedef enum logic {
    SRC_FRAME,
    SRC_SEND
  } src_t;

  // running keyword match flags
  typedef struct packed {
    logic ruok;
    logic runa;
    logic runb;
    logic zzz;
  } match_t;

  // command from the controller to the keyword matcher
  typedef struct packed {
    logic       start;
    logic       store;
    logic [7:0] data;
  } mcmd_t;

  // byte i of a text of length n, zero beyond its end
  function automatic logic [7:0] str_byte(logic [71:0] s, logic [3:0] n,
                                          logic [3:0] i);
    logic [3:0] k;
    k = n - 4'd1 - i;
    if (i >= n) begin
      return 8'h00;
    end
    return s[{k, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] txt_len(txt_t t);
    case (t)
      TXT_IMHERE:  return LEN_IMHERE;
      TXT_OK:      return LEN_OK;
      TXT_NOK:     return LEN_NOK;
      TXT_RUNNEDA: return LEN_RUNNEDA;
      TXT_RUNNEDB: return LEN_RUNNEDB;
      default:     return 4'd1;
    endcase
  endfunction

  function automatic logic [7:0] txt_byte(txt_t t, logic [3:0] i);
    case (t)
      TXT_IMHERE:  return str_byte(STR_IMHERE, LEN_IMHERE, i);
      TXT_OK:      return str_byte(STR_OK, LEN_OK, i);
      TXT_NOK:     return str_byte(STR_NOK, LEN_NOK, i);
      TXT_RUNNEDA: return str_byte(STR_RUNNEDA, LEN_RUNNEDA, i);
      TXT_RUNNEDB: return str_byte(STR_RUNNEDB, LEN_RUNNEDB, i);
      default:     return 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> sv/dcf_store.sv
// ----------------------------------------------------------------------------
// dcf_store
// Frame store and queued-send store: one write and one read port each,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_store #(
  parameter int BUF = 20
) (
  input  logic                                clk,
  input  logic                                frame_we,
  input  logic [$clog2(BUF)-1:0]              frame_waddr,
  input  logic [7:0]                          frame_wdata,
  input  logic                                frame_re,
  input  logic [$clog2(BUF)-1:0]              frame_raddr,
  output logic [7:0]                          frame_rdata,
  input  logic                                send_we,
  input  logic [dcf_pkg::SEND_AW-1:0]         send_waddr,
  input  logic [7:0]                          send_wdata,
  input  logic                                send_re,
  input  logic [dcf_pkg::SEND_AW-1:0]         send_raddr,
  output logic [7:0]                          send_rdata
);
  import dcf_pkg::*;

  logic [7:0] frame_mem [BUF];
  logic [7:0] send_mem  [SEND_DEPTH];

  // frame store: every entry read is written earlier in the same frame
  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_waddr] <= frame_wdata;
    end
    if (frame_re) begin
      frame_rdata <= frame_mem[frame_raddr];
    end
  end

  // queued-send store
  always_ff @(posedge clk) begin
    if (send_we) begin
      send_mem[send_waddr] <= send_wdata;
    end
    if (send_re) begin
      send_rdata <= send_mem[send_raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/dcf_matcher.sv
// ----------------------------------------------------------------------------
// dcf_matcher
// Keyword match flags, updated as each frame byte is stored, so that the
// keyword decision is ready when the terminator arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_matcher #(
  parameter int PW = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  dcf_pkg::mcmd_t  cmd,
  input  logic [PW-1:0]   pos,
  output dcf_pkg::match_t flags_next
);
  import dcf_pkg::*;

  match_t     flags;
  logic       near;
  logic [3:0] i4;

  // keywords are at most six bytes, so only low positions can match
  assign near = (pos < PW'(8));
  assign i4   = {1'b0, pos[2:0]};

  // next flags: a restart matches the leading slash of every keyword
  always_comb begin
    flags_next = flags;
    if (cmd.start) begin
      flags_next = '1;
    end else if (cmd.store) begin
      flags_next.ruok = flags.ruok && near &&
                        (str_byte(STR_RUOK, LEN_RUOK, i4) == cmd.data);
      flags_next.runa = flags.runa && near &&
                        (str_byte(STR_RUNA, LEN_RUNA, i4) == cmd.data);
      flags_next.runb = flags.runb && near &&
                        (str_byte(STR_RUNB, LEN_RUNB, i4) == cmd.data);
      flags_next.zzz  = flags.zzz && near &&
                        (str_byte(STR_ZZZ, LEN_ZZZ, i4) == cmd.data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      flags <= flags_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/delimited_command_framer_core.sv
// ----------------------------------------------------------------------------
// delimited_command_framer_core
// Frames '/'...'!' commands from line bytes, answers fixed keywords, hands
// held commands to the host and sends a host-loaded queued command.
//
//   channel  handshake                  payload
//   item     item_valid / item_stall    operation, data_byte, load_index,
//                                       load_last
//   result   result_valid / result_stall kind, out_byte, run_last,
//                                       frame_status, command_given
//
// An item is decoded in the idle state; answer text bytes then go to the
// result register one by one, and each byte from the frame or send store is
// first read, then loaded into the result register; a status-only result is
// loaded directly. Worst case is a /RUOK! with a full queued command.
// The result register lets the next item be taken while the last result
// still waits; result_stall holds the sequencer at the result register.
// Reset is synchronous and clears control state; store contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_command_framer_core #(
  parameter int BUF = 20
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] operation,
  input  logic [7:0] data_byte,
  input  logic [4:0] load_index,
  input  logic       load_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic [1:0] frame_status,
  output logic       command_given
);
  import dcf_pkg::*;

  localparam int FAW     = $clog2(BUF);
  localparam int PW      = $clog2(BUF + 1);
  localparam int LEN_MAX = (BUF > SEND_DEPTH) ? BUF : SEND_DEPTH;
  localparam int LW      = $clog2(LEN_MAX + 1);

  state_t         state, state_next;
  phase_t         phase, phase_next;
  logic [PW-1:0]  write_position, write_position_next;
  logic [PW-1:0]  frame_length, frame_length_next;
  logic [SEND_AW-1:0] send_length, send_length_next;
  logic           send_pending, send_pending_next;
  txt_t           txt_cur, txt_cur_next;
  txt_t           txt_nxt, txt_nxt_next;
  logic [LW-1:0]  idx, idx_next;
  logic [LW-1:0]  mem_len, mem_len_next;
  src_t           src, src_next;
  logic           given, given_next;

  // result register loading
  logic           out_free;
  logic           load;
  kind_t          ld_kind;
  logic [7:0]     ld_byte;
  logic           ld_last;
  logic           text_last;

  // store ports
  logic           frame_we, frame_re, send_we, send_re;
  logic [FAW-1:0] frame_waddr;
  logic [7:0]     frame_wdata, frame_rdata, send_rdata;

  // keyword matcher
  mcmd_t          mcmd;
  match_t         m_next;

  dcf_store #(.BUF(BUF)) u_store (
    .clk         (clk),
    .frame_we    (frame_we),
    .frame_waddr (frame_waddr),
    .frame_wdata (frame_wdata),
    .frame_re    (frame_re),
    .frame_raddr (idx[FAW-1:0]),
    .frame_rdata (frame_rdata),
    .send_we     (send_we),
    .send_waddr  (load_index),
    .send_wdata  (data_byte),
    .send_re     (send_re),
    .send_raddr  (idx[SEND_AW-1:0]),
    .send_rdata  (send_rdata)
  );

  dcf_matcher #(.PW(PW)) u_matcher (
    .clk        (clk),
    .rst        (rst),
    .cmd        (mcmd),
    .pos        (write_position),
    .flags_next (m_next)
  );

  assign item_stall = (state != ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign text_last  = (idx[TXT_IW-1:0] == (txt_len(txt_cur) - 4'd1));

  // matcher command: restart on a slash, store on an accepted frame byte
  always_comb begin
    mcmd      = '0;
    mcmd.data = data_byte;
    if (state == ST_IDLE && item_valid && op_t'(operation) == OP_LINE) begin
      if ((phase == PH_IDLE || phase == PH_RECV) && data_byte == CH_SLASH) begin
        mcmd.start = 1'b1;
      end else if (phase == PH_RECV && write_position < PW'(BUF)) begin
        mcmd.store = 1'b1;
      end
    end
  end

  // sequencer: decode an item, then emit its results one by one
  always_comb begin
    state_next          = state;
    phase_next          = phase;
    write_position_next = write_position;
    frame_length_next   = frame_length;
    send_length_next    = send_length;
    send_pending_next   = send_pending;
    txt_cur_next        = txt_cur;
    txt_nxt_next        = txt_nxt;
    idx_next            = idx;
    mem_len_next        = mem_len;
    src_next            = src;
    given_next          = given;
    frame_we            = 1'b0;
    frame_waddr         = write_position[FAW-1:0];
    frame_wdata         = data_byte;
    frame_re            = 1'b0;
    send_we             = 1'b0;
    send_re             = 1'b0;
    load                = 1'b0;
    ld_kind             = KIND_STATUS;
    ld_byte             = 8'h00;
    ld_last             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          given_next   = 1'b0;
          txt_nxt_next = TXT_NONE;
          mem_len_next = '0;
          idx_next     = '0;
          state_next   = ST_STATUS;
          case (op_t'(operation))
            OP_LINE: begin
              if ((phase == PH_IDLE || phase == PH_RECV) && data_byte == CH_SLASH) begin
                // a slash restarts the frame
                frame_we            = 1'b1;
                frame_waddr         = '0;
                frame_wdata         = CH_SLASH;
                write_position_next = PW'(1);
                frame_length_next   = '0;
                phase_next          = PH_RECV;
              end else if (phase == PH_RECV) begin
                if (write_position >= PW'(BUF)) begin
                  // frame too long: sticky error
                  phase_next   = PH_ERROR;
                  txt_cur_next = TXT_NOK;
                  state_next   = ST_TEXT;
                end else begin
                  frame_we            = 1'b1;
                  write_position_next = write_position + PW'(1);
                  if (data_byte == CH_BANG) begin
                    state_next = ST_TEXT;
                    if (m_next.ruok) begin
                      txt_cur_next        = TXT_IMHERE;
                      phase_next          = PH_IDLE;
                      write_position_next = '0;
                      frame_length_next   = '0;
                      if (send_pending) begin
                        mem_len_next = LW'(send_length);
                        src_next     = SRC_SEND;
                      end
                    end else begin
                      txt_cur_next = TXT_OK;
                      if (m_next.runa || m_next.runb || m_next.zzz) begin
                        phase_next          = PH_IDLE;
                        write_position_next = '0;
                        frame_length_next   = '0;
                        if (m_next.runa) begin
                          txt_nxt_next = TXT_RUNNEDA;
                        end else if (m_next.runb) begin
                          txt_nxt_next = TXT_RUNNEDB;
                        end
                      end else begin
                        phase_next        = PH_HELD;
                        frame_length_next = write_position + PW'(1);
                      end
                    end
                  end
                end
              end
            end
            OP_TAKE: begin
              if (phase == PH_HELD) begin
                phase_next   = PH_IDLE;
                given_next   = 1'b1;
                src_next     = SRC_FRAME;
                mem_len_next = LW'(frame_length);
                state_next   = ST_MEM_RD;
              end
            end
            OP_LOAD: begin
              if (load_index < SEND_AW'(SEND_DEPTH)) begin
                send_we = 1'b1;
                if (load_last) begin
                  send_length_next  = load_index + SEND_AW'(1);
                  send_pending_next = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_STATUS: begin
        if (out_free) begin
          load       = 1'b1;
          ld_kind    = KIND_STATUS;
          ld_last    = 1'b1;
          state_next = ST_IDLE;
        end
      end

      // fixed answer text, then an optional second text or store bytes
      ST_TEXT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = KIND_LINE;
          ld_byte = txt_byte(txt_cur, idx[TXT_IW-1:0]);
          ld_last = text_last && (txt_nxt == TXT_NONE) && (mem_len == '0);
          if (!text_last) begin
            idx_next = idx + LW'(1);
          end else if (txt_nxt != TXT_NONE) begin
            txt_cur_next = txt_nxt;
            txt_nxt_next = TXT_NONE;
            idx_next     = '0;
          end else if (mem_len != '0) begin
            idx_next   = '0;
            state_next = ST_MEM_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_MEM_RD: begin
        frame_re   = (src == SRC_FRAME);
        send_re    = (src == SRC_SEND);
        state_next = ST_MEM_OUT;
      end

      ST_MEM_OUT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_kind = (src == SRC_FRAME) ? KIND_HOST : KIND_LINE;
          ld_byte = (src == SRC_FRAME) ? frame_rdata : send_rdata;
          ld_last = (idx == mem_len - LW'(1));
          if (ld_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + LW'(1);
            state_next = ST_MEM_RD;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      phase          <= PH_IDLE;
      write_position <= '0;
      frame_length   <= '0;
      send_length    <= '0;
      send_pending   <= 1'b0;
      txt_cur        <= TXT_NONE;
      txt_nxt        <= TXT_NONE;
      idx            <= '0;
      mem_len        <= '0;
      src            <= SRC_FRAME;
      given          <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      write_position <= write_position_next;
      frame_length   <= frame_length_next;
      send_length    <= send_length_next;
      send_pending   <= send_pending_next;
      txt_cur        <= txt_cur_next;
      txt_nxt        <= txt_nxt_next;
      idx            <= idx_next;
      mem_len        <= mem_len_next;
      src            <= src_next;
      given          <= given_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (load) begin
      kind          <= ld_kind;
      out_byte      <= ld_byte;
      run_last      <= ld_last;
      frame_status  <= phase;
      command_given <= given;
    end
  end

`ifndef ASSERT_OFF
  ap_error_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |=> phase == PH_ERROR)
    else $error("error phase left without reset");

  ap_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    write_position <= PW'(BUF))
    else $error("write position beyond frame store");

  ap_held_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HELD |-> frame_length >= PW'(2))
    else $error("held command shorter than a delimiter pair");

  ap_pending_len: assert property (@(posedge clk) disable iff (rst)
    send_pending |-> send_length != '0)
    else $error("queued command pending with zero length");

  ap_last_idle: assert property (@(posedge clk) disable iff (rst)
    load && ld_last |=> state == ST_IDLE)
    else $error("sequencer busy after last result of an item");
`endif

endmodule

`default_nettype wire

>>> tb/sv/delimited_command_framer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_command_framer_core_tb
// Drives line bytes, host takes and queued-command loads into the framer and
// checks every result item against a cycle-free model of the framing,
// keyword answers, host hand-over and the sticky too-long error. Both sides
// pause at random; results are matched in order, field by field.
// ----------------------------------------------------------------------------
module delimited_command_framer_core_tb;
  import dcf_pkg::*;

  localparam int BUF         = 20;
  localparam int RAND_ITEMS  = 350;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    phase_t     status;
    logic       given;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] operation = OP_NOP;
  logic [7:0] data_byte = 8'h00;
  logic [4:0] load_index = 5'd0;
  logic       load_last = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       run_last;
  logic [1:0] frame_status;
  logic       command_given;

  // model state of the framer
  phase_t     line_phase = PH_IDLE;
  int         fill_pos = 0;
  int         frame_len = 0;
  logic [7:0] frame_bytes [BUF];
  logic [7:0] queued_bytes [SEND_DEPTH];
  bit         queued_loaded [SEND_DEPTH];
  int         queued_len = 0;
  bit         queued_armed = 1'b0;

  reply_t     reply_batch [$];
  reply_t     due_replies [$];
  int         errors = 0;
  int         effective_items = 0;
  int         cycle_count = 0;
  int         pause_left = 0;
  bit         no_idle = 1'b0;
  bit         guard_overflow = 1'b1;

  delimited_command_framer_core #(.BUF(BUF)) DUT (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .data_byte     (data_byte),
    .load_index    (load_index),
    .load_last     (load_last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .frame_status  (frame_status),
    .command_given (command_given)
  );

  always #1 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  task automatic add_reply(input kind_t k, input logic [7:0] b);
    reply_t r;
    r.kind   = k;
    r.data   = b;
    r.last   = 1'b0;
    r.status = PH_IDLE;
    r.given  = 1'b0;
    reply_batch.push_back(r);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_reply(KIND_LINE, s[i]);
  endtask

  function automatic bit frame_is(input string s);
    int i;
    if (frame_len != s.len()) return 1'b0;
    for (i = 0; i < s.len(); i++) begin
      if (frame_bytes[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_frame();
    int i;
    for (i = 0; i < BUF; i++) frame_bytes[i] = 8'h00;
    fill_pos  = 0;
    frame_len = 0;
  endtask

  task automatic start_frame();
    clear_frame();
    frame_bytes[0] = CH_SLASH;
    fill_pos       = 1;
    line_phase     = PH_RECV;
  endtask

  // work out the replies to one accepted item and queue them
  task automatic predict_replies(input op_t op, input logic [7:0] b, input logic [4:0] idx,
                                 input logic ld_last, output bit acted);
    reply_t r;
    bit     given;
    int     i;
    reply_batch.delete();
    given = 1'b0;
    acted = 1'b1;
    case (op)
      OP_LINE: begin
        if (line_phase == PH_IDLE && b == CH_SLASH) begin
          start_frame();
        end else if (line_phase != PH_RECV) begin
          acted = 1'b0;
        end else if (b == CH_SLASH) begin
          start_frame();
        end else if (fill_pos >= BUF) begin
          line_phase = PH_ERROR;
          add_text("/NOK!");
        end else begin
          frame_bytes[fill_pos] = b;
          fill_pos++;
          if (b == CH_BANG) begin
            frame_len = fill_pos;
            if (frame_is("/RUOK!")) begin
              add_text("/IMHERE!");
              clear_frame();
              line_phase = PH_IDLE;
              if (queued_armed) begin
                for (i = 0; i < queued_len; i++) add_reply(KIND_LINE, queued_bytes[i]);
              end
            end else begin
              add_text("/OK!");
              line_phase = PH_HELD;
              if (frame_is("/RUNA!")) begin
                clear_frame();
                line_phase = PH_IDLE;
                add_text("/RUNNEDA!");
              end else if (frame_is("/RUNB!")) begin
                clear_frame();
                line_phase = PH_IDLE;
                add_text("/RUNNEDB!");
              end else if (frame_is("/ZZZ!")) begin
                clear_frame();
                line_phase = PH_IDLE;
              end
            end
          end
        end
      end
      OP_TAKE: begin
        if (line_phase == PH_HELD) begin
          for (i = 0; i < frame_len; i++) add_reply(KIND_HOST, frame_bytes[i]);
          given      = 1'b1;
          line_phase = PH_IDLE;
        end else begin
          acted = 1'b0;
        end
      end
      OP_LOAD: begin
        if (idx < SEND_DEPTH) begin
          queued_bytes[idx]  = b;
          queued_loaded[idx] = 1'b1;
          if (ld_last) begin
            queued_len   = idx + 1;
            queued_armed = 1'b1;
          end
        end else begin
          acted = 1'b0;
        end
      end
      default: acted = 1'b0;
    endcase
    if (reply_batch.size() == 0) add_reply(KIND_STATUS, 8'h00);
    for (i = 0; i < reply_batch.size(); i++) begin
      r        = reply_batch[i];
      r.last   = (i == reply_batch.size() - 1);
      r.status = line_phase;
      r.given  = given;
      due_replies.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------- driving

  // present one item after a random gap and wait until it is taken
  task automatic send_item(input op_t op, input logic [7:0] b, input logic [4:0] idx,
                           input logic ld_last);
    int gap;
    int i;
    bit acted;
    // keep random traffic clear of the sticky error
    if (op == OP_LINE && guard_overflow && line_phase == PH_RECV && fill_pos >= BUF
        && b != CH_SLASH) b = CH_SLASH;
    // never arm a queued command that would read an unloaded entry
    if (op == OP_LOAD && ld_last && idx < SEND_DEPTH) begin
      for (i = 0; i < idx; i++) begin
        if (!queued_loaded[i]) ld_last = 1'b0;
      end
    end
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= op;
    data_byte  <= b;
    load_index <= idx;
    load_last  <= ld_last;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    predict_replies(op, b, idx, ld_last, acted);
    if (acted) effective_items++;
  endtask

  task automatic send_line(input logic [7:0] b);
    send_item(OP_LINE, b, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
  endtask

  task automatic host_take();
    send_item(OP_TAKE, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
              1'($urandom_range(0, 1)));
  endtask

  // '/' + keyword or random body + '!'
  task automatic send_frame(input string word, input int body_len);
    logic [7:0] b;
    int         i;
    send_line(CH_SLASH);
    if (word.len() > 0) begin
      for (i = 0; i < word.len(); i++) send_line(word[i]);
    end else begin
      for (i = 0; i < body_len; i++) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_SLASH || b == CH_BANG) b = b ^ 8'h80;
        send_line(b);
      end
    end
    send_line(CH_BANG);
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare each result item and pause the result side at random
  always @(posedge clk) begin : result_check
    reply_t want;
    if (!rst && result_valid === 1'b1 && result_stall == 1'b0) begin
      if (due_replies.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d byte %h",
                 $time, kind, out_byte);
        errors++;
      end else begin
        want = due_replies.pop_front();
        check_field("kind", 8'(want.kind), 8'(kind));
        check_field("out_byte", want.data, out_byte);
        check_field("run_last", 8'(want.last), 8'(run_last));
        check_field("frame_status", 8'(want.status), 8'(frame_status));
        check_field("command_given", 8'(want.given), 8'(command_given));
      end
      pause_left = no_idle ? 0 : $urandom_range(0, 8);
    end
    if (pause_left > 0) begin
      result_stall <= 1'b1;
      pause_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- tests

  // items that only give a status result
  task automatic test_idle_items();
    host_take();
    send_item(OP_NOP, 8'hFF, 5'd31, 1'b1);
    send_line(8'hFF);
    send_item(OP_LOAD, 8'hA5, 5'd31, 1'b1);
    send_item(OP_LOAD, 8'h5A, 5'(SEND_DEPTH), 1'b1);
  endtask

  // queued command with zero and all-ones bytes sent after /RUOK!
  task automatic test_queued_send();
    send_item(OP_LOAD, 8'h00, 5'd0, 1'b0);
    send_item(OP_LOAD, 8'hFF, 5'd1, 1'b1);
    send_frame("RUOK", 0);
  endtask

  // restart on '/', held command, '/' ignored while held, host take
  task automatic test_held_command();
    send_line(CH_SLASH);
    send_line(8'h78);
    send_line(CH_SLASH);
    send_line(8'h00);
    send_line(8'hFF);
    send_line(CH_BANG);
    send_line(CH_SLASH);
    host_take();
  endtask

  // mostly well-formed commands with random content, some noise
  task automatic test_random_traffic();
    int start;
    int pick;
    int len;
    int i;
    start = effective_items;
    while (effective_items - start < RAND_ITEMS) begin
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_frame("RUOK", 0);
      end else if (pick < 18) begin
        send_frame("RUNA", 0);
      end else if (pick < 24) begin
        send_frame("RUNB", 0);
      end else if (pick < 29) begin
        send_frame("ZZZ", 0);
      end else if (pick < 50) begin
        len = ($urandom_range(0, 3) == 0) ? BUF - 2 : $urandom_range(0, BUF - 2);
        send_frame("", len);
        if ($urandom_range(0, 3) != 0) host_take();
      end else if (pick < 60) begin
        len = $urandom_range(1, SEND_DEPTH);
        for (i = 0; i < len; i++) begin
          send_item(OP_LOAD, 8'($urandom_range(0, 255)), 5'(i), i == len - 1);
        end
      end else if (pick < 66) begin
        host_take();
      end else if (pick < 75) begin
        // broken frame with no terminator
        send_line(CH_SLASH);
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++) send_line(8'($urandom_range(0, 255)));
      end else begin
        send_item(op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                  5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end
    end
    no_idle = 1'b0;
  endtask

  // terminator with the store full: error that only reset leaves
  task automatic test_overlong_frame();
    if (line_phase == PH_HELD) host_take();
    guard_overflow = 1'b0;
    send_frame("", BUF - 1);
    send_frame("RUOK", 0);
    host_take();
    send_item(OP_LOAD, 8'h3C, 5'd0, 1'b1);
  endtask

  initial begin
    clear_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_idle_items();
    test_queued_send();
    test_held_command();
    test_random_traffic();
    test_overlong_frame();
    item_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
